// File: design/sus_pkg.sv
// Shared definitions for the sorted unique set block: request kinds,
// reply kinds and the default capacity. No dependencies.
`default_nettype none

package sus_pkg;

   localparam int SUS_CAPACITY = 64;
   localparam int SUS_DATA_W   = 32;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_LIST   = 2'd3
   } req_kind_type;

   localparam logic REPLY_SEARCH = 1'b0;
   localparam logic REPLY_LIST   = 1'b1;

endpackage

`default_nettype wire

// File: design/sus_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sus_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/sorted_unique_set.sv
// Top level of the sorted unique set: a sequencer that walks one RAM of
// ascending values for insert, remove, search and list requests.
// Depends on sus_pkg and sus_ram.
//
//   Channel   Ports                                   Handshake
//   request   req_kind, req_key_value                 start high while busy low
//   response  rsp_reply_kind, rsp_present,            rsp_valid for one cycle,
//             rsp_element, rsp_last                   receiver cannot stall
//
// One request is handled at a time and busy stays high until it is done.
// The scan passes each entry in a RAM read state, then a compare state, and
// an insert or remove moves each entry with a read, then a write; the two
// never cover the same entry. A list request reads each stored entry in
// turn and emits it as one response.
// Synchronous reset empties the set at once; there is no clearing pass.
`default_nettype none

module sorted_unique_set #(
   parameter int CAPACITY = sus_pkg::SUS_CAPACITY
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_kind,
   input  wire logic signed [sus_pkg::SUS_DATA_W-1:0] req_key_value,
   output logic                                    rsp_valid,
   output logic                                    rsp_reply_kind,
   output logic                                    rsp_present,
   output logic signed [sus_pkg::SUS_DATA_W-1:0]   rsp_element,
   output logic                                    rsp_last
);

   import sus_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN     = 4'd1;
   localparam logic [3:0] S_CMP      = 4'd2;
   localparam logic [3:0] S_INS      = 4'd3;
   localparam logic [3:0] S_INS_WR   = 4'd4;
   localparam logic [3:0] S_REM      = 4'd5;
   localparam logic [3:0] S_REM_WR   = 4'd6;
   localparam logic [3:0] S_LIST     = 4'd7;
   localparam logic [3:0] S_LIST_OUT = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [1:0]                    kind_ff, kind_in;
   logic signed [SUS_DATA_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              ptr_ff, ptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_reply_kind_ff, rsp_reply_kind_in;
   logic                          rsp_present_ff, rsp_present_in;
   logic signed [SUS_DATA_W-1:0]  rsp_element_ff, rsp_element_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [SUS_DATA_W-1:0]         wr_data;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic [SUS_DATA_W-1:0]         rd_data;

   logic signed [SUS_DATA_W-1:0]  rd_value;
   logic                          rd_less;
   logic                          rd_equal;
   logic                          resolve;
   logic                          found;
   logic [CNT_W-1:0]              ptr_inc;
   logic [CNT_W-1:0]              ptr_dec;

   sus_ram #(
      .WIDTH (SUS_DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The signed less-than and equality compares shared by every step of the scan.
   assign rd_value = $signed(rd_data);
   assign rd_less  = rd_value < key_ff;
   assign rd_equal = rd_value == key_ff;
   assign ptr_inc  = ptr_ff + CNT_W'(1);
   assign ptr_dec  = ptr_ff - CNT_W'(1);

   // The scan ends either at the end of the stored entries or at the first
   // entry that is not less than the key.
   assign resolve = ((state_ff == S_SCAN) && (idx_ff == count_ff)) ||
                    ((state_ff == S_CMP) && !rd_less);
   assign found   = (state_ff == S_CMP) && rd_equal;

   always_comb begin
      state_in          = state_ff;
      kind_in           = kind_ff;
      key_in            = key_ff;
      idx_in            = idx_ff;
      ptr_in            = ptr_ff;
      count_in          = count_ff;
      rsp_valid_in      = 1'b0;
      rsp_reply_kind_in = rsp_reply_kind_ff;
      rsp_present_in    = rsp_present_ff;
      rsp_element_in    = rsp_element_ff;
      rsp_last_in       = rsp_last_ff;
      wr_en             = 1'b0;
      wr_addr           = idx_ff[ADDR_W-1:0];
      wr_data           = key_ff;
      rd_en             = 1'b0;
      rd_addr           = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               key_in  = req_key_value;
               idx_in  = '0;
               ptr_in  = '0;
               state_in = (req_kind == KIND_LIST) ? S_LIST : S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff != count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[ADDR_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_less) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_SCAN;
            end
         end
         S_INS: begin
            if (ptr_ff == idx_ff) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[ADDR_W-1:0];
               wr_data  = key_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_dec[ADDR_W-1:0];
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[ADDR_W-1:0];
            wr_data  = rd_data;
            ptr_in   = ptr_dec;
            state_in = S_INS;
         end
         S_REM: begin
            if (ptr_inc == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_inc[ADDR_W-1:0];
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[ADDR_W-1:0];
            wr_data  = rd_data;
            ptr_in   = ptr_inc;
            state_in = S_REM;
         end
         S_LIST: begin
            if (ptr_ff == count_ff) begin
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff[ADDR_W-1:0];
               state_in = S_LIST_OUT;
            end
         end
         S_LIST_OUT: begin
            rsp_valid_in      = 1'b1;
            rsp_reply_kind_in = REPLY_LIST;
            rsp_present_in    = 1'b0;
            rsp_element_in    = rd_value;
            rsp_last_in       = ptr_inc == count_ff;
            ptr_in            = ptr_inc;
            state_in          = S_LIST;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (resolve) begin
         unique case (kind_ff)
            KIND_SEARCH: begin
               rsp_valid_in      = 1'b1;
               rsp_reply_kind_in = REPLY_SEARCH;
               rsp_present_in    = found;
               rsp_element_in    = '0;
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end
            KIND_INSERT: begin
               if (found || (count_ff == CNT_W'(CAPACITY))) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = count_ff;
                  state_in = S_INS;
               end
            end
            KIND_REMOVE: begin
               if (found) begin
                  ptr_in   = idx_ff;
                  state_in = S_REM;
               end else begin
                  state_in = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      key_ff            <= key_in;
      idx_ff            <= idx_in;
      ptr_ff            <= ptr_in;
      rsp_reply_kind_ff <= rsp_reply_kind_in;
      rsp_present_ff    <= rsp_present_in;
      rsp_element_ff    <= rsp_element_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_reply_kind_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_element    = rsp_element_ff;
   assign rsp_last       = rsp_last_ff;

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // An accepted request always leaves the idle state on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the block busy");

   // The RAM is only written while a request is in progress.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy)
      else $error("RAM written while idle");

   // A search answer is always the final response of its request.
   a_search_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reply_kind == REPLY_SEARCH)) |-> rsp_last)
      else $error("search answer without last mark");

endmodule

`default_nettype wire
